[rtl/core/gtph_pkg.sv]
// ----------------------------------------------------------------------------
// gtph_pkg
// Shared types and constants for the grid triangle plane height block.
// ----------------------------------------------------------------------------
package gtph_pkg;

    localparam int FRAC_BITS          = 12;
    localparam int CELL_UNITS_DEF     = 16;
    localparam int MAX_SIDE_CELLS_DEF = 32;

    // operation codes (input tuser)
    localparam logic [1:0] OP_QUERY = 2'd0;
    localparam logic [1:0] OP_PLANE = 2'd1;
    localparam logic [1:0] OP_CELL  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // fault codes (output tuser)
    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_OUTSIDE = 2'd1;
    localparam logic [1:0] FAULT_NY_ZERO = 2'd2;

    // register indexes
    localparam logic REG_CELLS = 1'b0;
    localparam logic REG_BASE  = 1'b1;

    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 112;

    // divider: 48-bit dividend, 14-bit divisor, two quotient bits per stage
    localparam int DIV_W     = 48;
    localparam int DEN_W     = 14;
    localparam int DIV_STEPS = 2;
    localparam int DIV_STG   = DIV_W / DIV_STEPS;

    typedef struct packed {
        logic signed [13:0] nx;
        logic signed [13:0] ny;
        logic signed [13:0] nz;
        logic signed [31:0] d;
    } t_plane;

    typedef struct packed {
        logic [1:0]         op;
        logic [9:0]         cell_num;
        logic               psel;
        t_plane             plane;
        logic               split;
        logic [31:0]        attr;
        logic signed [22:0] x;
        logic signed [22:0] z;
    } t_item;

    // result fields that ride alongside the divider
    typedef struct packed {
        logic signed [13:0] nx;
        logic signed [13:0] ny;
        logic signed [13:0] nz;
        logic [31:0]        attr;
        logic [1:0]         fault;
        logic               qneg;
    } t_side;

endpackage

[rtl/core/gtph_div.sv]
// ----------------------------------------------------------------------------
// gtph_div
// Pipelined unsigned restoring divider, two quotient bits per stage,
// carrying a side payload and a valid bit with every beat.
// ----------------------------------------------------------------------------
module gtph_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [gtph_pkg::DIV_W-1:0]  i_dividend,
    input  logic [gtph_pkg::DEN_W-1:0]  i_divisor,
    input  gtph_pkg::t_side             i_side,
    output logic                        o_valid,
    output logic [gtph_pkg::DIV_W-1:0]  o_quotient,
    output gtph_pkg::t_side             o_side
);
    import gtph_pkg::*;

    logic              r_vld  [DIV_STG];
    logic [DIV_W-1:0]  r_num  [DIV_STG];
    logic [DEN_W-1:0]  r_rem  [DIV_STG];
    logic [DEN_W-1:0]  r_den  [DIV_STG];
    t_side             r_side [DIV_STG];

    logic [DIV_W-1:0]  n_num  [DIV_STG];
    logic [DEN_W-1:0]  n_rem  [DIV_STG];

    // stage inputs: the port for stage 0, the previous register otherwise
    logic [DIV_W-1:0]  w_src_num [DIV_STG];
    logic [DEN_W-1:0]  w_src_rem [DIV_STG];
    logic [DEN_W-1:0]  w_src_den [DIV_STG];

    always_comb begin
        w_src_num[0] = i_dividend;
        w_src_rem[0] = '0;
        w_src_den[0] = i_divisor;
        for (int s = 1; s < DIV_STG; s++) begin
            w_src_num[s] = r_num[s-1];
            w_src_rem[s] = r_rem[s-1];
            w_src_den[s] = r_den[s-1];
        end
    end

    // num shifts left; quotient bits fill in from the bottom
    always_comb begin
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [DEN_W:0]   trial;
        for (int s = 0; s < DIV_STG; s++) begin
            num = w_src_num[s];
            rem = w_src_rem[s];
            den = w_src_den[s];
            for (int k = 0; k < DIV_STEPS; k++) begin
                trial = {rem, num[DIV_W-1]};
                num   = {num[DIV_W-2:0], 1'b0};
                if (trial >= {1'b0, den}) begin
                    trial  = trial - {1'b0, den};
                    num[0] = 1'b1;
                end
                rem = trial[DEN_W-1:0];
            end
            n_num[s] = num;
            n_rem[s] = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STG; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < DIV_STG; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 0; s < DIV_STG; s++) begin
                r_num[s] <= n_num[s];
                r_rem[s] <= n_rem[s];
                r_den[s] <= w_src_den[s];
            end
            for (int s = 1; s < DIV_STG; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    assign o_valid    = r_vld[DIV_STG-1];
    assign o_quotient = r_num[DIV_STG-1];
    assign o_side     = r_side[DIV_STG-1];

endmodule

[rtl/core/grid_triangle_plane_height.sv]
// ----------------------------------------------------------------------------
// grid_triangle_plane_height
// Cell map with two planes per cell; answers height queries at x,z.
// ----------------------------------------------------------------------------
// Depth: 7 front stages, 24 divider stages, output register. Writes give
//   no result beat; the 24-stage divider sets the depth.
// Throughput: one beat per cycle while m_axis_tready does not stall it.
// Reset: synchronous, active low; clears valid bits and config registers
//   (cells_per_side 32, base_height 0). Map memories are not cleared.
module grid_triangle_plane_height #(
    parameter int CELL_UNITS     = gtph_pkg::CELL_UNITS_DEF,
    parameter int MAX_SIDE_CELLS = gtph_pkg::MAX_SIDE_CELLS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // stream in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cell_number, plane_select, normal_x_in, normal_y_in, normal_z_in,
    // plane_offset, split_type, cell_attribute, pos_x, pos_z
    input  logic [gtph_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // operation
    input  logic [1:0]                        s_axis_tuser,
    // stream out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // height, normal_x_out, normal_y_out, normal_z_out, attribute_out
    output logic [gtph_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // fault
    output logic [1:0]                        m_axis_tuser,
    // config
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import gtph_pkg::*;

    localparam int NUM_CELLS = MAX_SIDE_CELLS * MAX_SIDE_CELLS;
    localparam int IDX_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int NW        = $clog2(MAX_SIDE_CELLS + 1);
    localparam int QW        = (MAX_SIDE_CELLS > 1) ? $clog2(MAX_SIDE_CELLS) : 1;
    localparam int LOGW      = $clog2(MAX_SIDE_CELLS * CELL_UNITS);
    localparam int PW0       = LOGW + FRAC_BITS + 1;
    localparam int PW        = ((PW0 > 23) ? PW0 : 23) + 1;
    localparam int UW        = PW - 1 - FRAC_BITS;
    localparam int GW        = $clog2(CELL_UNITS) + FRAC_BITS;
    localparam longint RECIP_L = ((64'sd1 <<< 32) + CELL_UNITS - 1) / CELL_UNITS;
    localparam logic [32:0]   RECIP = 33'(RECIP_L);
    localparam logic [PW-1:0] CW_P  = PW'(CELL_UNITS * (1 << FRAC_BITS));
    localparam logic [GW:0]   CW_G  = (GW+1)'(CELL_UNITS * (1 << FRAC_BITS));

    // ---------------- config ----------------
    logic [5:0]         r_cells;
    logic signed [31:0] r_base;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= 6'd32;
            r_base  <= '0;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_CELLS) begin
                r_cells <= pwdata[5:0];
            end else begin
                r_base <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == REG_CELLS) ? {26'd0, r_cells} : r_base;

    logic [NW-1:0]        w_n;
    logic signed [PW-1:0] w_width;
    logic signed [PW-1:0] w_half;

    always_comb begin
        if (r_cells == 6'd0) begin
            w_n = NW'(1);
        end else if (int'(r_cells) > MAX_SIDE_CELLS) begin
            w_n = NW'(MAX_SIDE_CELLS);
        end else begin
            w_n = NW'(r_cells);
        end
        w_width = PW'(w_n) * CW_P;
        w_half  = w_width >>> 1;
    end

    // ---------------- pipeline control ----------------
    logic r_o_valid;
    logic w_en;

    assign w_en          = !r_o_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    t_item w_in;
    assign w_in.op       = s_axis_tuser;
    assign w_in.cell_num = s_axis_tdata[9:0];
    assign w_in.psel     = s_axis_tdata[10];
    assign w_in.plane.nx = s_axis_tdata[24:11];
    assign w_in.plane.ny = s_axis_tdata[38:25];
    assign w_in.plane.nz = s_axis_tdata[52:39];
    assign w_in.plane.d  = s_axis_tdata[84:53];
    assign w_in.split = s_axis_tdata[85];
    assign w_in.attr  = s_axis_tdata[117:86];
    assign w_in.x     = s_axis_tdata[140:118];
    assign w_in.z     = s_axis_tdata[163:141];

    // stage valids: a..d carry all beats, e..g queries only
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld, r_g_vld;
    t_item r_a, r_b, r_c, r_d;

    // stage B: position within map
    logic signed [PW-1:0] r_b_px, r_b_pz;
    logic                 r_b_out;
    logic signed [PW-1:0] w_px, w_pz;

    assign w_px = PW'(r_a.x) + w_half;
    assign w_pz = PW'(r_a.z) + w_half;

    // stage C: cell column/row by reciprocal multiply
    logic [QW-1:0]        r_c_qx, r_c_qz;
    logic signed [PW-1:0] r_c_px, r_c_pz;
    logic                 r_c_out;
    logic [UW+32:0]       w_mx, w_mz;

    assign w_mx = (UW+33)'(r_b_px[PW-2:FRAC_BITS]) * (UW+33)'(RECIP);
    assign w_mz = (UW+33)'(r_b_pz[PW-2:FRAC_BITS]) * (UW+33)'(RECIP);

    // stage D: cell index and offsets within cell
    logic [IDX_W-1:0] r_d_idx;
    logic [GW-1:0]    r_d_gx, r_d_gz;
    logic             r_d_out;
    logic [PW-1:0]    w_gx_full, w_gz_full;

    assign w_gx_full = r_c_px - PW'(r_c_qx) * CW_P;
    assign w_gz_full = r_c_pz - PW'(r_c_qz) * CW_P;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= s_axis_tvalid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a <= w_in;
            r_b <= r_a;
            r_c <= r_b;
            r_d <= r_c;

            r_b_px  <= w_px;
            r_b_pz  <= w_pz;
            r_b_out <= (w_px < 0) || (w_pz < 0) || (w_px >= w_width) || (w_pz >= w_width);

            r_c_qx  <= w_mx[32 +: QW];
            r_c_qz  <= w_mz[32 +: QW];
            r_c_px  <= r_b_px;
            r_c_pz  <= r_b_pz;
            r_c_out <= r_b_out;

            r_d_idx <= IDX_W'(r_c_qz) * IDX_W'(w_n) + IDX_W'(r_c_qx);
            r_d_gx  <= GW'(w_gx_full);
            r_d_gz  <= GW'(w_gz_full);
            r_d_out <= r_c_out;
        end
    end

    // ---------------- map memories (stage D -> E) ----------------
    t_plane      mem_p0   [NUM_CELLS];
    t_plane      mem_p1   [NUM_CELLS];
    logic        mem_split[NUM_CELLS];
    logic [31:0] mem_attr [NUM_CELLS];

    logic             w_cell_ok;
    logic [IDX_W-1:0] w_waddr;

    assign w_cell_ok = int'(r_d.cell_num) < NUM_CELLS;
    assign w_waddr   = IDX_W'(r_d.cell_num);

    t_plane      r_e_p0, r_e_p1;
    logic        r_e_split;
    logic [31:0] r_e_attr;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_d_vld && w_cell_ok && r_d.op == OP_PLANE) begin
                if (r_d.psel) begin
                    mem_p1[w_waddr] <= r_d.plane;
                end else begin
                    mem_p0[w_waddr] <= r_d.plane;
                end
            end
            if (r_d_vld && w_cell_ok && r_d.op == OP_CELL) begin
                mem_split[w_waddr] <= r_d.split;
                mem_attr[w_waddr]  <= r_d.attr;
            end
            r_e_p0    <= mem_p0[r_d_idx];
            r_e_p1    <= mem_p1[r_d_idx];
            r_e_split <= mem_split[r_d_idx];
            r_e_attr  <= mem_attr[r_d_idx];
        end
    end

    logic [GW-1:0]      r_e_gx, r_e_gz;
    logic               r_e_out;
    logic signed [22:0] r_e_x, r_e_z;

    // ---------------- stage E: plane pick and products ----------------
    logic               w_sel;
    t_plane             w_pl;
    logic signed [14:0] w_nnz;
    logic signed [13:0] w_onz;
    t_side              w_e_side;

    always_comb begin
        if (r_e_split == 1'b0) begin
            w_sel = ((GW+1)'(r_e_gx) + (GW+1)'(r_e_gz)) >= CW_G;
        end else begin
            w_sel = !(r_e_gx > r_e_gz);
        end
        w_pl  = w_sel ? r_e_p1 : r_e_p0;
        w_nnz = -15'(w_pl.nz);
        w_onz = (w_nnz > 15'sd8191) ? 14'sd8191 : 14'(w_nnz);
        w_e_side.qneg = 1'b0;
        if (r_e_out) begin
            w_e_side.nx    = '0;
            w_e_side.ny    = '0;
            w_e_side.nz    = '0;
            w_e_side.attr  = '0;
            w_e_side.fault = FAULT_OUTSIDE;
        end else begin
            w_e_side.nx    = w_pl.nx;
            w_e_side.ny    = w_pl.ny;
            w_e_side.nz    = w_onz;
            w_e_side.attr  = r_e_attr;
            w_e_side.fault = (w_pl.ny == 14'sd0) ? FAULT_NY_ZERO : FAULT_NONE;
        end
    end

    logic signed [36:0] r_f_prx;
    logic signed [37:0] r_f_prz;
    logic signed [31:0] r_f_d;
    t_side              r_f_side;

    // ---------------- stage F: rounding and sum ----------------
    logic signed [38:0] w_rx, w_rz;
    logic signed [33:0] w_sum;

    assign w_rx  = 39'(r_f_prx) + 39'sd2048;
    assign w_rz  = 39'(r_f_prz) + 39'sd2048;
    assign w_sum = 34'(w_rx >>> FRAC_BITS) + 34'(w_rz >>> FRAC_BITS) + 34'(r_f_d);

    logic signed [33:0] r_g_sum;
    t_side              r_g_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else if (w_en) begin
            r_e_vld <= r_d_vld && (r_d.op == OP_QUERY);
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_gx   <= r_d_gx;
            r_e_gz   <= r_d_gz;
            r_e_out  <= r_d_out;
            r_e_x    <= r_d.x;
            r_e_z    <= r_d.z;

            r_f_prx  <= 37'(w_pl.nx) * 37'(r_e_x);
            r_f_prz  <= 38'(w_nnz) * 38'(r_e_z);
            r_f_d    <= w_pl.d;
            r_f_side <= w_e_side;

            r_g_sum  <= w_sum;
            r_g_side <= r_f_side;
        end
    end

    // ---------------- stage G: signs off, into divider ----------------
    logic signed [34:0] w_num;
    logic [34:0]        w_mag;
    logic [DIV_W-1:0]   w_dividend;
    logic [DEN_W-1:0]   w_den;
    t_side              w_g_side;

    always_comb begin
        w_num      = -35'(r_g_sum);
        w_mag      = (w_num < 0) ? 35'(-w_num) : 35'(w_num);
        w_dividend = DIV_W'({w_mag, {FRAC_BITS{1'b0}}});
        w_den      = (r_g_side.ny < 0) ? DEN_W'(-r_g_side.ny) : DEN_W'(r_g_side.ny);
        w_g_side      = r_g_side;
        w_g_side.qneg = (w_num < 0) ^ (r_g_side.ny < 0);
    end

    logic             w_dv_vld;
    logic [DIV_W-1:0] w_quo;
    t_side            w_dv_side;

    gtph_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_g_vld),
        .i_dividend (w_dividend),
        .i_divisor  (w_den),
        .i_side     (w_g_side),
        .o_valid    (w_dv_vld),
        .o_quotient (w_quo),
        .o_side     (w_dv_side)
    );

    // ---------------- output stage: sign, base, saturate ----------------
    logic signed [DIV_W:0]   w_qs;
    logic signed [DIV_W+1:0] w_h;
    logic signed [31:0]      w_hsat;

    always_comb begin
        w_qs = w_dv_side.qneg ? -(DIV_W+1)'(w_quo) : (DIV_W+1)'(w_quo);
        w_h  = (DIV_W+2)'(w_qs) + (DIV_W+2)'(r_base);
        if (w_h > (DIV_W+2)'(32'sh7FFF_FFFF)) begin
            w_hsat = 32'sh7FFF_FFFF;
        end else if (w_h < -(DIV_W+2)'(64'sh8000_0000)) begin
            w_hsat = 32'sh8000_0000;
        end else begin
            w_hsat = 32'(w_h);
        end
        if (w_dv_side.fault != FAULT_NONE) begin
            w_hsat = '0;
        end
    end

    t_side              r_o_side;
    logic signed [31:0] r_o_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_h    <= w_hsat;
            r_o_side <= w_dv_side;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {6'd0, r_o_side.attr, r_o_side.nz, r_o_side.ny,
                            r_o_side.nx, r_o_h};
    assign m_axis_tuser  = r_o_side.fault;

endmodule
